/* rtl/core/psfw_pkg.sv */
// package for the peer silence freeze watchdog
// holds sizes, register codes, reset values and item structs; no dependencies
package psfw_pkg;

  localparam int PEER_SLOTS = 10;
  localparam int IDX_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 4;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  localparam logic [CNT_W-1:0] CNT_MAX      = 4'd15;
  localparam logic [15:0]      THR_RESET    = 16'd3000;
  localparam logic [15:0]      LEAK_RESET   = 16'd500;

  typedef enum logic [0:0] {
    REG_FREEZE_THRESHOLD = 1'b0,
    REG_LEAK_INTERVAL    = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_OBSERVE = 1'b0,
    OP_LEAK    = 1'b1
  } op_t;

  // tdata payload, first field in the highest bits
  typedef struct packed {
    logic              game_paused;
    logic              session_active;
    logic [31:0]       msg_stamp;
    logic              is_remote_human;
    logic [31:0]       local_id;
    logic [31:0]       peer_id;
    logic              peer_active;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       now_ms;
  } obs_data_t;

  typedef struct packed {
    op_t       op;
    logic      frame_last;
    obs_data_t data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] frozen_duration_ms;
    logic        resumed_event;
    logic        froze_event;
    logic        delta_value;
    logic        delta_override;
    logic        frozen;
  } res_t;

  typedef struct packed {
    logic             clear;
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [31:0]      stamp;
    logic [31:0]      rx_ms;
  } store_wr_t;

endpackage

/* rtl/core/peer_silence_freeze_watchdog_unit.sv */
// peer silence freeze watchdog, top level
// path from input request to result: input register, then result register
// throughput: one request per cycle while the result channel is not stalled; state is updated in the single pass stage
// reset (rst_n, synchronous): peer store and freeze state cleared, registers at defaults
// depends on psfw_pkg and psfw_peer_store
module peer_silence_freeze_watchdog_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: now_ms, slot, peer_active, peer_id, local_id, is_remote_human,
  //        msg_stamp, session_active, game_paused
  input  logic [psfw_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: op
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: frozen, delta_override, delta_value, froze_event, resumed_event,
  //        frozen_duration_ms, zero fill
  output logic [psfw_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [15:0]                    cfg_data
);
  import psfw_pkg::*;

  in_item_t         in_r, in_nxt;
  logic             in_vld_r, in_vld_nxt;
  res_t             out_r, out_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [15:0]      thr_r, thr_nxt;
  logic [15:0]      leak_r, leak_nxt;
  logic             freeze_r, freeze_nxt;
  logic [31:0]      since_r, since_nxt;
  logic [31:0]      last_leak_r, last_leak_nxt;
  logic [31:0]      newest_r, newest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             skipped_r, skipped_nxt;

  logic             adv, fire;
  store_wr_t        st_wr;
  logic [31:0]      rd_stamp, rd_rx;
  logic             skip_now, slot_ok, eligible, upd;
  logic [31:0]      rx_new, newest_cur, silence, leak_gap;
  logic [CNT_W-1:0] count_cur;
  obs_data_t        d;

  assign adv       = !out_vld_r || out_tready;
  assign fire      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // input register
  always_comb begin
    in_nxt     = in_r;
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_nxt.op         = op_t'(in_tuser);
      in_nxt.frame_last = in_tlast;
      in_nxt.data       = obs_data_t'(in_tdata);
      in_vld_nxt        = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  // configuration
  always_comb begin
    thr_nxt  = thr_r;
    leak_nxt = leak_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FREEZE_THRESHOLD: thr_nxt  = cfg_data;
        REG_LEAK_INTERVAL:    leak_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign d = in_r.data;

  psfw_peer_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (st_wr),
    .rd_idx   (d.slot[IDX_W-1:0]),
    .rd_stamp (rd_stamp),
    .rd_rx_ms (rd_rx)
  );

  // single pass over one request
  always_comb begin
    skip_now   = skipped_r || !d.session_active || (d.game_paused && !freeze_r);
    slot_ok    = ({1'b0, d.slot} < (SLOT_W + 1)'(PEER_SLOTS));
    eligible   = !skip_now && d.peer_active && (d.peer_id != '0) &&
                 (d.peer_id != d.local_id) && d.is_remote_human && slot_ok;
    upd        = eligible && ((rd_rx == '0) || (rd_stamp != d.msg_stamp));
    rx_new     = upd ? d.now_ms : rd_rx;
    count_cur  = (eligible && (count_r < CNT_MAX)) ? count_r + 1'b1 : count_r;
    newest_cur = (eligible && (rx_new > newest_r)) ? rx_new : newest_r;
    silence    = d.now_ms - newest_cur;
    leak_gap   = d.now_ms - last_leak_r;

    st_wr.clear = fire && (in_r.op == OP_OBSERVE) &&
                  (!d.session_active || (d.game_paused && !freeze_r));
    st_wr.we    = fire && (in_r.op == OP_OBSERVE) && upd;
    st_wr.idx   = d.slot[IDX_W-1:0];
    st_wr.stamp = d.msg_stamp;
    st_wr.rx_ms = d.now_ms;

    freeze_nxt    = freeze_r;
    since_nxt     = since_r;
    last_leak_nxt = last_leak_r;
    newest_nxt    = newest_r;
    count_nxt     = count_r;
    skipped_nxt   = skipped_r;
    out_nxt       = '0;

    if (in_r.op == OP_LEAK) begin
      if (freeze_r) begin
        out_nxt.delta_override = 1'b1;
        if (leak_gap >= {16'd0, leak_r}) begin
          last_leak_nxt       = d.now_ms;
          out_nxt.delta_value = 1'b1;
        end
      end
    end else begin
      if (!d.session_active) begin
        freeze_nxt = 1'b0;
      end
      if (in_r.frame_last) begin
        if (!skip_now) begin
          if (count_cur == '0) begin
            freeze_nxt = 1'b0;
          end else if (!freeze_r && (silence >= {16'd0, thr_r})) begin
            freeze_nxt          = 1'b1;
            since_nxt           = d.now_ms;
            last_leak_nxt       = '0;
            out_nxt.froze_event = 1'b1;
          end else if (freeze_r && (silence < {16'd0, thr_r})) begin
            out_nxt.frozen_duration_ms = d.now_ms - since_r;
            freeze_nxt            = 1'b0;
            since_nxt             = '0;
            out_nxt.resumed_event = 1'b1;
          end
        end
        newest_nxt  = '0;
        count_nxt   = '0;
        skipped_nxt = 1'b0;
      end else begin
        newest_nxt  = newest_cur;
        count_nxt   = count_cur;
        skipped_nxt = skip_now;
      end
    end
    out_nxt.frozen = freeze_nxt;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      thr_r       <= THR_RESET;
      leak_r      <= LEAK_RESET;
      freeze_r    <= 1'b0;
      since_r     <= '0;
      last_leak_r <= '0;
      newest_r    <= '0;
      count_r     <= '0;
      skipped_r   <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      thr_r     <= thr_nxt;
      leak_r    <= leak_nxt;
      if (fire) begin
        freeze_r    <= freeze_nxt;
        since_r     <= since_nxt;
        last_leak_r <= last_leak_nxt;
        newest_r    <= newest_nxt;
        count_r     <= count_nxt;
        skipped_r   <= skipped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.froze_event && out_r.resumed_event))
    else $error("freeze and resume on one result");

  a_leak_needs_override: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.delta_value) |-> out_r.delta_override)
    else $error("delta value without override");

  a_event_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((!out_r.froze_event || out_r.frozen) &&
                   (!out_r.resumed_event || !out_r.frozen)))
    else $error("event disagrees with frozen flag");

  a_rise_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(freeze_r) |-> (out_vld_r && out_r.froze_event))
    else $error("freeze began without event");

  a_duration_only_on_resume: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.resumed_event) |-> (out_r.frozen_duration_ms == '0))
    else $error("duration without resume");

endmodule

/* rtl/core/psfw_peer_store.sv */
// per-slot store of last message stamp and last receive time
// depends on psfw_pkg; valid bits make a cleared or unwritten slot read zero
module psfw_peer_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  psfw_pkg::store_wr_t      wr,
  input  logic [psfw_pkg::IDX_W-1:0] rd_idx,
  output logic [31:0]              rd_stamp,
  output logic [31:0]              rd_rx_ms
);
  import psfw_pkg::*;

  logic [PEER_SLOTS-1:0] vld_r;
  logic [PEER_SLOTS-1:0] vld_nxt;
  logic [31:0]           stamp_r [PEER_SLOTS];
  logic [31:0]           rx_r    [PEER_SLOTS];
  logic                  rd_ok;

  always_comb begin
    vld_nxt = vld_r;
    if (wr.clear) begin
      vld_nxt = '0;
    end
    if (wr.we) begin
      vld_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      stamp_r[wr.idx] <= wr.stamp;
      rx_r[wr.idx]    <= wr.rx_ms;
    end
  end

  assign rd_ok    = ({1'b0, rd_idx} < (IDX_W + 1)'(PEER_SLOTS)) && vld_r[rd_idx];
  assign rd_stamp = rd_ok ? stamp_r[rd_idx] : '0;
  assign rd_rx_ms = rd_ok ? rx_r[rd_idx] : '0;

endmodule

/* tb/peer_silence_freeze_watchdog_unit_tb.sv */
// testbench for peer_silence_freeze_watchdog_unit: directed and random frames of peer
// observations and leak queries, checked against a predictor of the freeze state machine
// depends on psfw_pkg and the watchdog rtl
module peer_silence_freeze_watchdog_unit_tb;
  import psfw_pkg::*;

  localparam int LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  peer_silence_freeze_watchdog_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] thr_cfg = THR_RESET;
  logic [15:0] leak_cfg = LEAK_RESET;
  logic [31:0] stamp_seen [PEER_SLOTS] = '{default: '0};
  logic [31:0] rx_at [PEER_SLOTS] = '{default: '0};
  logic        frozen_st = 1'b0;
  logic [31:0] frozen_from = '0;
  logic [31:0] leaked_at = '0;
  logic [31:0] newest_rx = '0;
  logic [3:0]  peer_cnt = '0;
  logic        skip_frame = 1'b0;

  res_t        verdict_q [$];
  int          errors = 0;
  int          items_sent = 0;
  int          cycles = 0;
  logic        no_gaps = 1'b0;
  int          stall_reqs = 0;
  int          stall_seen = 0;
  int          stall_left = 0;

  // stimulus state
  logic [31:0] now_ms_cur = '0;
  logic [31:0] my_id = 32'h0000_1234;
  logic [31:0] ids [PEER_SLOTS];
  logic [31:0] stamps [PEER_SLOTS] = '{default: '0};
  logic        chatty = 1'b1;

  function automatic res_t predict_verdict(in_item_t it);
    res_t        r;
    obs_data_t   d;
    logic [31:0] silence;
    logic        elig;
    r = '0;
    d = it.data;
    if (it.op == OP_LEAK) begin
      if (frozen_st) begin
        r.delta_override = 1'b1;
        if (32'(d.now_ms - leaked_at) >= {16'h0, leak_cfg}) begin
          leaked_at = d.now_ms;
          r.delta_value = 1'b1;
        end
      end
    end else begin
      if (!d.session_active) begin
        frozen_st = 1'b0;
        stamp_seen = '{default: '0};
        rx_at = '{default: '0};
        skip_frame = 1'b1;
      end else if (d.game_paused && !frozen_st) begin
        stamp_seen = '{default: '0};
        rx_at = '{default: '0};
        skip_frame = 1'b1;
      end
      elig = d.peer_active && d.peer_id != 0 && d.peer_id != d.local_id &&
             d.is_remote_human && d.slot < PEER_SLOTS;
      if (!skip_frame && elig) begin
        if (peer_cnt != CNT_MAX) peer_cnt = peer_cnt + 1'b1;
        if (rx_at[d.slot] == 0 || stamp_seen[d.slot] != d.msg_stamp) begin
          stamp_seen[d.slot] = d.msg_stamp;
          rx_at[d.slot] = d.now_ms;
        end
        if (rx_at[d.slot] > newest_rx) newest_rx = rx_at[d.slot];
      end
      if (it.frame_last) begin
        if (!skip_frame) begin
          if (peer_cnt == 0) begin
            frozen_st = 1'b0;
          end else begin
            silence = d.now_ms - newest_rx;
            if (!frozen_st && silence >= {16'h0, thr_cfg}) begin
              frozen_st = 1'b1;
              frozen_from = d.now_ms;
              leaked_at = '0;
              r.froze_event = 1'b1;
            end else if (frozen_st && silence < {16'h0, thr_cfg}) begin
              r.frozen_duration_ms = d.now_ms - frozen_from;
              frozen_st = 1'b0;
              frozen_from = '0;
              r.resumed_event = 1'b1;
            end
          end
        end
        newest_rx = '0;
        peer_cnt = '0;
        skip_frame = 1'b0;
      end
    end
    r.frozen = frozen_st;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0h", $time, out_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        check_field("frozen", 32'(want.frozen), 32'(got.frozen));
        check_field("delta_override", 32'(want.delta_override), 32'(got.delta_override));
        check_field("delta_value", 32'(want.delta_value), 32'(got.delta_value));
        check_field("froze_event", 32'(want.froze_event), 32'(got.froze_event));
        check_field("resumed_event", 32'(want.resumed_event), 32'(got.resumed_event));
        check_field("frozen_duration_ms", want.frozen_duration_ms, got.frozen_duration_ms);
      end
    end
  end

  // result sink with random stalls and long hold-offs on request
  always @(posedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen <= stall_reqs;
      stall_left <= 300;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_request(in_item_t it);
    while (!no_gaps && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tuser  <= it.op;
    in_tlast  <= it.frame_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    verdict_q.push_back(predict_verdict(it));
    items_sent++;
  endtask

  task automatic send_obs(logic [3:0] s, logic last, logic act, logic [31:0] pid,
                          logic [31:0] lid, logic rem, logic [31:0] st, logic sess,
                          logic paus);
    in_item_t it;
    it.op = OP_OBSERVE;
    it.frame_last = last;
    it.data.now_ms = now_ms_cur;
    it.data.slot = s;
    it.data.peer_active = act;
    it.data.peer_id = pid;
    it.data.local_id = lid;
    it.data.is_remote_human = rem;
    it.data.msg_stamp = st;
    it.data.session_active = sess;
    it.data.game_paused = paus;
    push_request(it);
  endtask

  task automatic send_peer(logic [3:0] s, logic last, logic [31:0] st);
    send_obs(s, last, 1'b1, ids[s], my_id, 1'b1, st, 1'b1, 1'b0);
  endtask

  task automatic send_random(logic is_leak, logic [31:0] t);
    in_item_t     it;
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it.op = is_leak ? OP_LEAK : op_t'(bits[140]);
    it.frame_last = bits[150];
    it.data = bits[IN_DATA_W-1:0];
    if (is_leak) it.data.now_ms = t;
    push_request(it);
  endtask

  task automatic send_slot(logic [3:0] s, logic last, logic sess, logic paus);
    logic [31:0] pid;
    logic [31:0] st;
    logic        act;
    logic        rem;
    int          r;
    act = 1'b1;
    rem = 1'b1;
    if (s < PEER_SLOTS) begin
      if ($urandom_range(0, 99) < 2) ids[s] = $urandom;
      if (chatty && $urandom_range(0, 1)) stamps[s] = $urandom;
      pid = ids[s];
      st = stamps[s];
    end else begin
      pid = $urandom;
      st = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 2) pid = '0;
    else if (r < 4) pid = my_id;
    else if (r < 6) act = 1'b0;
    else if (r < 8) rem = 1'b0;
    send_obs(s, last, act, pid, my_id, rem, st, sess, paus);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] thr, logic [15:0] leak);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FREEZE_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_cfg = thr;
    cfg_index <= REG_LEAK_INTERVAL;
    cfg_data  <= leak;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    leak_cfg = leak;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(int count, int step_max);
    int   stop;
    int   len;
    logic sess;
    logic paus;
    logic whole;
    logic [3:0] s;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 3) now_ms_cur = $urandom;
      else now_ms_cur += $urandom_range(0, step_max);
      if ($urandom_range(0, 99) < 15) chatty = !chatty;
      if ($urandom_range(0, 99) < 5) my_id = $urandom;
      sess = ($urandom_range(0, 99) >= 3);
      paus = ($urandom_range(0, 99) < 6);
      whole = ($urandom_range(0, 99) < 80);
      len = whole ? PEER_SLOTS : $urandom_range(1, 18);
      for (int n = 0; n < len; n++) begin
        s = whole ? 4'(n) : 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 5) send_random(1'b1, now_ms_cur);
        if ($urandom_range(0, 99) < 2) send_random(1'b0, '0);
        else send_slot(s, n == len - 1, sess, paus);
      end
      while ($urandom_range(0, 99) < 35) begin
        now_ms_cur += $urandom_range(0, step_max / 2 + 1);
        send_random(1'b1, now_ms_cur);
      end
    end
  endtask

  task automatic test_directed();
    for (int i = 0; i < PEER_SLOTS; i++) ids[i] = 32'h100 + i;
    now_ms_cur = 32'd1000;
    send_peer(4'd0, 1'b0, 32'h1);
    send_obs(4'd1, 1'b0, 1'b1, 32'h0, my_id, 1'b1, $urandom, 1'b1, 1'b0);
    send_obs(4'd2, 1'b0, 1'b1, my_id, my_id, 1'b1, $urandom, 1'b1, 1'b0);
    send_obs(4'd3, 1'b0, 1'b1, ids[3], my_id, 1'b0, $urandom, 1'b1, 1'b0);
    send_obs(4'd4, 1'b0, 1'b0, ids[4], my_id, 1'b1, $urandom, 1'b1, 1'b0);
    send_obs(4'hF, 1'b0, 1'b1, '1, '0, 1'b1, '1, 1'b1, 1'b0);
    send_peer(4'd5, 1'b1, 32'h5);
    // silent for exactly the threshold
    now_ms_cur = 32'd4000;
    send_peer(4'd0, 1'b0, 32'h1);
    send_peer(4'd5, 1'b1, 32'h5);
    send_random(1'b1, 32'd4000);
    send_random(1'b1, 32'd4499);
    send_random(1'b1, 32'd4500);
    // paused while frozen keeps tracking
    now_ms_cur = 32'd4600;
    send_obs(4'd0, 1'b1, 1'b1, ids[0], my_id, 1'b1, 32'h1, 1'b1, 1'b1);
    now_ms_cur = 32'd5000;
    send_peer(4'd0, 1'b1, 32'h2);
    // paused while running skips the frame
    now_ms_cur = 32'd5100;
    send_obs(4'd0, 1'b0, 1'b1, ids[0], my_id, 1'b1, 32'h2, 1'b1, 1'b1);
    send_peer(4'd5, 1'b1, 32'h5);
    now_ms_cur = 32'd5200;
    send_obs(4'd0, 1'b1, 1'b1, ids[0], my_id, 1'b1, 32'h2, 1'b0, 1'b1);
    // zero clock, then wrap of the clock
    now_ms_cur = 32'd0;
    send_peer(4'd0, 1'b1, 32'h7);
    now_ms_cur = 32'hFFFF_FF00;
    send_peer(4'd0, 1'b1, 32'h7);
    now_ms_cur = 32'h0000_0BB8;
    send_peer(4'd0, 1'b1, 32'h7);
    send_random(1'b1, 32'hFFFF_FFFF);
    // no eligible peer left ends the freeze
    now_ms_cur = 32'h0000_0C00;
    send_obs(4'd0, 1'b1, 1'b1, 32'h0, my_id, 1'b1, 32'h7, 1'b1, 1'b0);
    send_random(1'b1, now_ms_cur);
  endtask

  task automatic test_register_extremes();
    settle();
    program_regs(16'd0, 16'd0);
    run_frames(60, 50);
    settle();
    program_regs(16'hFFFF, 16'hFFFF);
    run_frames(100, 40000);
    settle();
    program_regs(16'd1, 16'd1);
    run_frames(40, 3);
  endtask

  task automatic test_random_frames();
    int thr;
    settle();
    program_regs(16'd200, 16'd40);
    run_frames(300, 120);
    settle();
    program_regs(16'd1000, 16'd300);
    run_frames(300, 600);
    settle();
    thr = $urandom_range(1, 4000);
    program_regs(16'(thr), 16'($urandom_range(1, thr)));
    run_frames(300, thr / 2 + 1);
  endtask

  task automatic test_backpressure();
    settle();
    program_regs(THR_RESET, LEAK_RESET);
    stall_reqs++;
    run_frames(60, 1500);
    no_gaps = 1'b1;
    run_frames(100, 1500);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_frames();
    test_backpressure();
    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/core/psfw_pkg.sv
rtl/core/psfw_peer_store.sv
rtl/core/peer_silence_freeze_watchdog_unit.sv
tb/peer_silence_freeze_watchdog_unit_tb.sv
